// ===== src/ptq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptq_pkg: shared types and constants of the periodic timer queue
// Holds the entry layout, the cell control word and the sizing constants.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned MaxPops    = 63;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned PopW       = $clog2(MaxPops + 1);
  localparam int unsigned TimeW      = 48;
  localparam int unsigned DelayW     = 21;

  localparam logic [DelayW-1:0] DelayMax = DelayW'(2000000);
  localparam logic [9:0]        DelayPad = 10'd500;

  localparam logic [1:0] KindAdd   = 2'd0;
  localparam logic [1:0] KindFire  = 2'd1;
  localparam logic [1:0] KindDelay = 2'd2;

  typedef struct packed {
    logic [7:0]       id;
    logic [TimeW-1:0] due;
    logic [31:0]      per;
    logic [TimeW-1:0] stop;
    logic             en;
    logic [31:0]      cnt;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

// ===== src/periodic_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_queue_top: sorted periodic timer queue
// Chain of 64 cells sorted by due time with a sequencer for add and service.
// ----------------------------------------------------------------------------
// An add beat is accepted, then inserted and answered. A service beat is
// accepted and checked; each due timer is popped from the front cell, then
// reinserted into the chain if it repeats, and dispatched if it fired; the
// wait delay is answered last. Each pop and each insert is one shift of
// the cell chain; results wait for the output register to be free.
module periodic_timer_queue_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // item_id[7:0], first_run_time[55:8], repeat_period[87:56],
  // end_time[135:88], enabled[136], now_time[184:137], zero fill
  input  logic [191:0]  s_axis_tdata,
  // mode[0]
  input  logic [0:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status[0], occupancy[7:1], fired_id[15:8], fired_count[47:16],
  // delay_us[68:48], zero fill
  output logic [71:0]   m_axis_tdata,
  // kind[1:0]
  output logic [1:0]    m_axis_tuser,
  output logic          m_axis_tlast
);
  import ptq_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StAdd   = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StReins = 3'd3;
  localparam logic [2:0] StFire  = 3'd4;
  localparam logic [2:0] StDelay = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [PopW-1:0]  pops_q, pops_d;
  entry_t           in_q, pop_q, pop_d;
  logic [TimeW-1:0] now_q;
  logic             fired_q, fired_d, reins_q, reins_d;

  logic             ovalid_q, ovalid_d;
  logic [1:0]       okind_q, okind_d;
  logic             ostat_q, ostat_d, olast_q, olast_d;
  logic [6:0]       oocc_q, oocc_d;
  logic [7:0]       oid_q, oid_d;
  logic [31:0]      ocnt_q, ocnt_d;
  logic [DelayW-1:0] odly_q, odly_d;

  cell_ctl_t        ctl;
  entry_t           ins_ent;
  entry_t           ents [QueueDepth];
  logic             stays [QueueDepth];

  logic             accept, out_free, ended, fired;
  logic [TimeW:0]   nd;
  logic signed [TimeW+1:0] diff;
  logic [DelayW-1:0] delay;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle);

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_s;
    if (g == 0) begin : g_first
      assign prev_e = ins_ent;
      assign prev_s = 1'b1;
    end else begin : g_mid
      assign prev_e = ents[g-1];
      assign prev_s = stays[g-1];
    end
    if (g == QueueDepth - 1) begin : g_last
      assign next_e = ins_ent;
    end else begin : g_nlast
      assign next_e = ents[g+1];
    end
    ptq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (CntW'(g) < count_q),
      .new_i       (ins_ent),
      .prev_i      (prev_e),
      .prev_stay_i (prev_s),
      .next_i      (next_e),
      .ent_o       (ents[g]),
      .stay_o      (stays[g])
    );
  end

  assign ended = (ents[0].stop != '0) && (ents[0].stop < now_q);
  assign fired = !ended && ents[0].en;
  assign nd    = {1'b0, pop_q.due} + {{(TimeW-31){1'b0}}, pop_q.per};
  assign diff  = $signed({2'b00, ents[0].due}) - $signed({2'b00, now_q})
               + $signed({{(TimeW-8){1'b0}}, DelayPad});

  always_comb begin
    if (count_q == '0) begin
      delay = DelayMax;
    end else if (diff < 0) begin
      delay = '0;
    end else if (diff > $signed({{(TimeW+2-DelayW){1'b0}}, DelayMax})) begin
      delay = DelayMax;
    end else begin
      delay = diff[DelayW-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pops_d   = pops_q;
    pop_d    = pop_q;
    fired_d  = fired_q;
    reins_d  = reins_q;
    ctl      = '0;
    ins_ent  = (state_q == StReins) ? pop_q : in_q;
    if (state_q == StReins) begin
      ins_ent.due = nd[TimeW-1:0];
    end
    ovalid_d = ovalid_q && !m_axis_tready;
    okind_d  = okind_q;
    ostat_d  = ostat_q;
    olast_d  = olast_q;
    oocc_d   = oocc_q;
    oid_d    = oid_q;
    ocnt_d   = ocnt_q;
    odly_d   = odly_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          pops_d  = '0;
          state_d = s_axis_tuser[0] ? StCheck : StAdd;
        end
      end
      StAdd: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = KindAdd;
          ostat_d  = (count_q >= CntW'(QueueDepth));
          oid_d    = '0;
          ocnt_d   = '0;
          odly_d   = '0;
          olast_d  = 1'b1;
          if (!ostat_d) begin
            ctl.ins = 1'b1;
            count_d = count_q + 1'b1;
          end
          oocc_d  = 7'(count_d);
          state_d = StIdle;
        end
      end
      StCheck: begin
        if ((count_q != '0) && (pops_q < PopW'(MaxPops)) && (ents[0].due < now_q)) begin
          pop_d   = ents[0];
          fired_d = fired;
          reins_d = !ended && (ents[0].per != '0);
          if (fired && (ents[0].cnt != '1)) begin
            pop_d.cnt = ents[0].cnt + 1'b1;
          end
          ctl.pop = 1'b1;
          count_d = count_q - 1'b1;
          pops_d  = pops_q + 1'b1;
          state_d = StReins;
        end else begin
          state_d = StDelay;
        end
      end
      StReins: begin
        if (reins_q && !nd[TimeW]
            && ((pop_q.stop == '0) || (nd[TimeW-1:0] < pop_q.stop))) begin
          ctl.ins = 1'b1;
          count_d = count_q + 1'b1;
        end
        state_d = fired_q ? StFire : StCheck;
      end
      StFire: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = KindFire;
          ostat_d  = 1'b0;
          oocc_d   = 7'(count_q);
          oid_d    = pop_q.id;
          ocnt_d   = pop_q.cnt;
          odly_d   = '0;
          olast_d  = 1'b0;
          state_d  = StCheck;
        end
      end
      StDelay: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = KindDelay;
          ostat_d  = 1'b0;
          oocc_d   = 7'(count_q);
          oid_d    = '0;
          ocnt_d   = '0;
          odly_d   = delay;
          olast_d  = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      pops_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pops_q   <= pops_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.id    <= s_axis_tdata[7:0];
      in_q.due   <= s_axis_tdata[55:8];
      in_q.per   <= s_axis_tdata[87:56];
      in_q.stop  <= s_axis_tdata[135:88];
      in_q.en    <= s_axis_tdata[136];
      in_q.cnt   <= '0;
      now_q      <= s_axis_tdata[184:137];
    end
    pop_q   <= pop_d;
    fired_q <= fired_d;
    reins_q <= reins_d;
    okind_q <= okind_d;
    ostat_q <= ostat_d;
    olast_q <= olast_d;
    oocc_q  <= oocc_d;
    oid_q   <= oid_d;
    ocnt_q  <= ocnt_d;
    odly_q  <= odly_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {3'b000, odly_q, ocnt_q, oid_q, oocc_q, ostat_q};

endmodule

// ===== src/ptq_cell.sv =====
// ----------------------------------------------------------------------------
// ptq_cell: one slot of the sorted timer chain
// Keeps its entry on insert when it sorts ahead of the new timer, otherwise
// takes the new timer or its left neighbor; shifts from the right on pop.
// ----------------------------------------------------------------------------
module ptq_cell (
  input  logic            clk_i,
  input  ptq_pkg::cell_ctl_t ctl_i,
  input  logic            valid_i,
  input  ptq_pkg::entry_t new_i,
  input  ptq_pkg::entry_t prev_i,
  input  logic            prev_stay_i,
  input  ptq_pkg::entry_t next_i,
  output ptq_pkg::entry_t ent_o,
  output logic            stay_o
);
  import ptq_pkg::*;

  entry_t ent_q;

  // equal due times stay ahead of the newcomer
  assign stay_o = valid_i && (ent_q.due <= new_i.due);
  assign ent_o  = ent_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pop) begin
      ent_q <= next_i;
    end else if (ctl_i.ins && !stay_o) begin
      ent_q <= prev_stay_i ? new_i : prev_i;
    end
  end

endmodule
